/* rtl/vtp_pkg.sv */
// Package: types, widths and register codes for the virtual trackball projection.
`default_nettype none
package vtp_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int OUT_FRAC_BITS   = 14;

  // magnitude of centred coordinate, in half-fraction units
  localparam int MAG_W  = ((17 > 12 + COORD_FRAC_BITS) ? 17 : 12 + COORD_FRAC_BITS) + 1;
  localparam int X_W    = MAG_W + 1;
  localparam int D_W    = 2 * MAG_W + 1;
  localparam int RH_W   = 24 + 2 * COORD_FRAC_BITS + 1;
  localparam int SQ_W0  = ((D_W > RH_W + 1) ? D_W : RH_W + 1) + 1;
  localparam int SQ_W   = SQ_W0 + (SQ_W0 % 2);
  localparam int RT_W   = SQ_W / 2;
  localparam int CN_W   = RT_W + OUT_FRAC_BITS;
  localparam int MAX_MAG = 32767;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_RADIUS_SQ    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
  } vtp_in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               on_sphere;
    logic               degenerate;
  } vtp_out_t;

  // sideband carried along the first square root
  typedef struct packed {
    logic             sphere;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [D_W-1:0]   d;
  } sq1_tag_t;

  // sideband along the hyperbolic divide
  typedef struct packed {
    logic [RT_W-1:0]  s;
    logic             sphere;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [D_W-1:0]   d;
  } dv1_tag_t;

  // sideband along the length square root
  typedef struct packed {
    logic             sphere;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [RT_W-1:0]  z;
  } sq2_tag_t;

  typedef struct packed {
    logic sphere;
    logic sx;
    logic sy;
  } dv2_tag_t;

endpackage
`default_nettype wire

/* rtl/virtual_trackball_projection.sv */
// Top level: config registers, cell chains for roots and divides, output register.
// The pipe runs through the front stages and the digit cells of two square roots and two
// divides in series, with the z and length registers before the second root.
// Throughput: one point per cycle; the whole pipe stalls only when the output is held.
// Reset (rst_n low, synchronous) empties the pipe and loads the default registers:
// width 640, height 480, centre offsets 0, radius squared 57600.
`default_nettype none
module virtual_trackball_projection (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire vtp_pkg::vtp_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output vtp_pkg::vtp_out_t                      out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vtp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vtp_pkg::*;

  logic [11:0]        img_w_r, img_h_r;
  logic signed [11:0] ctr_x_r, ctr_y_r;
  logic [23:0]        rsq_r;
  logic [RH_W-1:0]    rh;
  logic               en;

  assign cfg_ready = 1'b1;
  assign rh        = RH_W'(rsq_r) << (2 * COORD_FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 12'd640;
      img_h_r <= 12'd480;
      ctr_x_r <= '0;
      ctr_y_r <= '0;
      rsq_r   <= 24'd57600;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data[11:0];
        CFG_CENTER_X:     ctr_x_r <= cfg_data[11:0];
        CFG_CENTER_Y:     ctr_y_r <= cfg_data[11:0];
        CFG_RADIUS_SQ:    rsq_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic     out_valid_r;
  vtp_out_t out_data_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // front
  logic [SQ_W-1:0] f_rad;
  sq1_tag_t        f_tag;
  logic            f_v;

  vtp_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(in_valid && in_ready), .in_data(in_data),
    .img_w(img_w_r), .img_h(img_h_r), .ctr_x(ctr_x_r), .ctr_y(ctr_y_r), .rh(rh),
    .v_out(f_v), .rad_out(f_rad), .tag_out(f_tag)
  );

  // first root: sqrt(2Rh - d) on the sphere, sqrt(d) on the sheet
  logic            a_v    [0:RT_W];
  logic [SQ_W-1:0] a_rad  [0:RT_W];
  logic [RT_W:0]   a_rem  [0:RT_W];
  logic [RT_W-1:0] a_root [0:RT_W];
  sq1_tag_t        a_tag  [0:RT_W];

  assign a_v[0]    = f_v;
  assign a_rad[0]  = f_rad;
  assign a_rem[0]  = '0;
  assign a_root[0] = '0;
  assign a_tag[0]  = f_tag;

  for (genvar i = 0; i < RT_W; i++) begin : g_sq1
    vtp_sqrt_cell #(.SW(SQ_W), .HW(RT_W), .TW($bits(sq1_tag_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(a_v[i]), .rad_in(a_rad[i]), .rem_in(a_rem[i]), .root_in(a_root[i]),
      .tag_in(a_tag[i]),
      .v_out(a_v[i+1]), .rad_out(a_rad[i+1]), .rem_out(a_rem[i+1]),
      .root_out(a_root[i+1]), .tag_out(a_tag[i+1])
    );
  end

  // hyperbolic sheet: Rh / s
  logic                      b_v    [0:RH_W];
  logic [0:0][RH_W-1:0]      b_num  [0:RH_W];
  logic [0:0][RT_W-1:0]      b_rem  [0:RH_W];
  logic [0:0][RH_W-1:0]      b_quot [0:RH_W];
  logic [RT_W-1:0]           b_den  [0:RH_W];
  dv1_tag_t                  b_tag  [0:RH_W];

  assign b_v[0]    = a_v[RT_W];
  assign b_num[0]  = rh;
  assign b_rem[0]  = '0;
  assign b_quot[0] = '0;
  assign b_den[0]  = a_root[RT_W];
  assign b_tag[0]  = '{s: a_root[RT_W], sphere: a_tag[RT_W].sphere, sx: a_tag[RT_W].sx,
                       sy: a_tag[RT_W].sy, ax: a_tag[RT_W].ax, ay: a_tag[RT_W].ay,
                       d: a_tag[RT_W].d};

  for (genvar i = 0; i < RH_W; i++) begin : g_dv1
    vtp_div_cell #(.LANES(1), .NW(RH_W), .DVW(RT_W), .TW($bits(dv1_tag_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(b_v[i]), .num_in(b_num[i]), .rem_in(b_rem[i]), .quot_in(b_quot[i]),
      .den_in(b_den[i]), .tag_in(b_tag[i]),
      .v_out(b_v[i+1]), .num_out(b_num[i+1]), .rem_out(b_rem[i+1]),
      .quot_out(b_quot[i+1]), .den_out(b_den[i+1]), .tag_out(b_tag[i+1])
    );
  end

  // z select, z squared, length squared
  logic            m1_v_r, m2_v_r;
  logic [RT_W-1:0] z_sel;
  logic [RT_W-1:0] z1_r;
  logic [SQ_W-1:0] zz_r;
  logic [SQ_W-1:0] len2_r;
  dv1_tag_t        m1_tag_r;
  sq2_tag_t        m2_tag_r;
  dv1_tag_t        b_end;

  assign b_end = b_tag[RH_W];
  assign z_sel = b_end.sphere ? b_end.s : b_quot[RH_W][0][RT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= b_v[RH_W];
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r     <= z_sel;
      zz_r     <= z_sel * z_sel;
      m1_tag_r <= b_end;
      len2_r   <= SQ_W'(m1_tag_r.d) + zz_r;
      m2_tag_r <= '{sphere: m1_tag_r.sphere, sx: m1_tag_r.sx, sy: m1_tag_r.sy,
                    ax: m1_tag_r.ax, ay: m1_tag_r.ay, z: z1_r};
    end
  end

  // vector length
  logic            c_v    [0:RT_W];
  logic [SQ_W-1:0] c_rad  [0:RT_W];
  logic [RT_W:0]   c_rem  [0:RT_W];
  logic [RT_W-1:0] c_root [0:RT_W];
  sq2_tag_t        c_tag  [0:RT_W];

  assign c_v[0]    = m2_v_r;
  assign c_rad[0]  = len2_r;
  assign c_rem[0]  = '0;
  assign c_root[0] = '0;
  assign c_tag[0]  = m2_tag_r;

  for (genvar i = 0; i < RT_W; i++) begin : g_sq2
    vtp_sqrt_cell #(.SW(SQ_W), .HW(RT_W), .TW($bits(sq2_tag_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(c_v[i]), .rad_in(c_rad[i]), .rem_in(c_rem[i]), .root_in(c_root[i]),
      .tag_in(c_tag[i]),
      .v_out(c_v[i+1]), .rad_out(c_rad[i+1]), .rem_out(c_rem[i+1]),
      .root_out(c_root[i+1]), .tag_out(c_tag[i+1])
    );
  end

  // normalize: lanes are x, y, z
  logic                 e_v    [0:CN_W];
  logic [2:0][CN_W-1:0] e_num  [0:CN_W];
  logic [2:0][RT_W-1:0] e_rem  [0:CN_W];
  logic [2:0][CN_W-1:0] e_quot [0:CN_W];
  logic [RT_W-1:0]      e_den  [0:CN_W];
  dv2_tag_t             e_tag  [0:CN_W];

  assign e_v[0]       = c_v[RT_W];
  assign e_num[0][0]  = CN_W'(c_tag[RT_W].ax) << OUT_FRAC_BITS;
  assign e_num[0][1]  = CN_W'(c_tag[RT_W].ay) << OUT_FRAC_BITS;
  assign e_num[0][2]  = CN_W'(c_tag[RT_W].z) << OUT_FRAC_BITS;
  assign e_rem[0]     = '0;
  assign e_quot[0]    = '0;
  assign e_den[0]     = c_root[RT_W];
  assign e_tag[0]     = '{sphere: c_tag[RT_W].sphere, sx: c_tag[RT_W].sx,
                          sy: c_tag[RT_W].sy};

  for (genvar i = 0; i < CN_W; i++) begin : g_dv2
    vtp_div_cell #(.LANES(3), .NW(CN_W), .DVW(RT_W), .TW($bits(dv2_tag_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(e_v[i]), .num_in(e_num[i]), .rem_in(e_rem[i]), .quot_in(e_quot[i]),
      .den_in(e_den[i]), .tag_in(e_tag[i]),
      .v_out(e_v[i+1]), .num_out(e_num[i+1]), .rem_out(e_rem[i+1]),
      .quot_out(e_quot[i+1]), .den_out(e_den[i+1]), .tag_out(e_tag[i+1])
    );
  end

  // saturate, sign, zero-length override
  logic [2:0][14:0] mg;
  logic [2:0][15:0] comp;
  logic [2:0]       neg;
  logic             degen;
  vtp_out_t         out_data_nxt;

  always_comb begin
    neg   = {1'b0, e_tag[CN_W].sy, e_tag[CN_W].sx};
    degen = (e_den[CN_W] == '0);
    for (int i = 0; i < 3; i++) begin
      mg[i]   = (e_quot[CN_W][i] > CN_W'(MAX_MAG)) ? 15'(MAX_MAG) : e_quot[CN_W][i][14:0];
      comp[i] = neg[i] ? -{1'b0, mg[i]} : {1'b0, mg[i]};
      if (degen) begin
        comp[i] = '0;
      end
    end
    out_data_nxt.dir_x      = comp[0];
    out_data_nxt.dir_y      = comp[1];
    out_data_nxt.dir_z      = comp[2];
    out_data_nxt.on_sphere  = e_tag[CN_W].sphere;
    out_data_nxt.degenerate = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_v[CN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a zero-length vector only arises from the centre point on the sphere
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0)
    else $error("degenerate result with nonzero components");

  a_degen_sphere: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.on_sphere)
    else $error("degenerate result off the sphere");

  a_sheet_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.on_sphere |-> !out_data.degenerate && !out_data.dir_z[15])
    else $error("hyperbolic result with zero length or negative z");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> !in_ready || out_valid)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

/* rtl/vtp_sqrt_cell.sv */
// One digit of a pipelined integer square root: consumes two radicand bits per cell.
`default_nettype none
module vtp_sqrt_cell #(
  parameter int SW = 38,
  parameter int HW = 19,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_in,
  input  wire logic [SW-1:0] rad_in,
  input  wire logic [HW:0]   rem_in,
  input  wire logic [HW-1:0] root_in,
  input  wire logic [TW-1:0] tag_in,
  output logic               v_out,
  output logic [SW-1:0]      rad_out,
  output logic [HW:0]        rem_out,
  output logic [HW-1:0]      root_out,
  output logic [TW-1:0]      tag_out
);

  logic [HW+2:0] t;
  logic [HW+2:0] trial;
  logic          ge;
  logic          v_r;
  logic [SW-1:0] rad_r;
  logic [HW:0]   rem_r;
  logic [HW-1:0] root_r;
  logic [TW-1:0] tag_r;
  logic [HW:0]   rem_nxt;

  always_comb begin
    t       = {rem_in, rad_in[SW-1 -: 2]};
    trial   = {1'b0, root_in, 2'b01};
    ge      = (t >= trial);
    rem_nxt = ge ? (HW+1)'(t - trial) : t[HW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_in << 2;
      rem_r  <= rem_nxt;
      root_r <= {root_in[HW-2:0], ge};
      tag_r  <= tag_in;
    end
  end

  assign v_out    = v_r;
  assign rad_out  = rad_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign tag_out  = tag_r;

endmodule
`default_nettype wire

/* rtl/vtp_div_cell.sv */
// One quotient bit of a pipelined restoring divide, several numerators over one divisor.
`default_nettype none
module vtp_div_cell #(
  parameter int LANES = 1,
  parameter int NW    = 33,
  parameter int DVW   = 19,
  parameter int TW    = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       v_in,
  input  wire logic [LANES-1:0][NW-1:0]   num_in,
  input  wire logic [LANES-1:0][DVW-1:0]  rem_in,
  input  wire logic [LANES-1:0][NW-1:0]   quot_in,
  input  wire logic [DVW-1:0]             den_in,
  input  wire logic [TW-1:0]              tag_in,
  output logic                            v_out,
  output logic [LANES-1:0][NW-1:0]        num_out,
  output logic [LANES-1:0][DVW-1:0]       rem_out,
  output logic [LANES-1:0][NW-1:0]        quot_out,
  output logic [DVW-1:0]                  den_out,
  output logic [TW-1:0]                   tag_out
);

  logic [LANES-1:0][DVW:0]   t;
  logic [LANES-1:0]          ge;
  logic [LANES-1:0][DVW-1:0] rem_nxt;
  logic                      v_r;
  logic [LANES-1:0][NW-1:0]  num_r;
  logic [LANES-1:0][DVW-1:0] rem_r;
  logic [LANES-1:0][NW-1:0]  quot_r;
  logic [DVW-1:0]            den_r;
  logic [TW-1:0]             tag_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      t[i]       = {rem_in[i], num_in[i][NW-1]};
      ge[i]      = (t[i] >= {1'b0, den_in});
      rem_nxt[i] = ge[i] ? DVW'(t[i] - {1'b0, den_in}) : t[i][DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        num_r[i]  <= num_in[i] << 1;
        rem_r[i]  <= rem_nxt[i];
        quot_r[i] <= {quot_in[i][NW-2:0], ge[i]};
      end
      den_r <= den_in;
      tag_r <= tag_in;
    end
  end

  assign v_out    = v_r;
  assign num_out  = num_r;
  assign rem_out  = rem_r;
  assign quot_out = quot_r;
  assign den_out  = den_r;
  assign tag_out  = tag_r;

endmodule
`default_nettype wire

/* rtl/vtp_front.sv */
// Front stages: centring, squaring, region test and first square-root radicand.
`default_nettype none
module vtp_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     v_in,
  input  wire vtp_pkg::vtp_in_t         in_data,
  input  wire logic [11:0]              img_w,
  input  wire logic [11:0]              img_h,
  input  wire logic signed [11:0]       ctr_x,
  input  wire logic signed [11:0]       ctr_y,
  input  wire logic [vtp_pkg::RH_W-1:0] rh,
  output logic                          v_out,
  output logic [vtp_pkg::SQ_W-1:0]      rad_out,
  output vtp_pkg::sq1_tag_t             tag_out
);
  import vtp_pkg::*;

  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;
  logic [X_W-1:0]        nx;
  logic [X_W-1:0]        ny;

  logic             v1_r, v2_r, v3_r;
  logic             sx1_r, sy1_r, sx2_r, sy2_r;
  logic [MAG_W-1:0] ax1_r, ay1_r, ax2_r, ay2_r;
  logic [2*MAG_W-1:0] sqx_r, sqy_r;
  logic [D_W-1:0]   d;
  logic             sphere;
  logic [SQ_W-1:0]  rad_nxt;
  logic [SQ_W-1:0]  rad_r;
  sq1_tag_t         tag_r;

  always_comb begin
    x  = (X_W'(img_w) << COORD_FRAC_BITS) - (X_W'(in_data.point_x) << 1)
         - (X_W'(ctr_x) << (COORD_FRAC_BITS + 1));
    y  = (X_W'(img_h) << COORD_FRAC_BITS) - (X_W'(in_data.point_y) << 1)
         - (X_W'(ctr_y) << (COORD_FRAC_BITS + 1));
    nx = -x;
    ny = -y;
  end

  always_comb begin
    d       = D_W'(sqx_r) + D_W'(sqy_r);
    sphere  = (SQ_W'(d) <= SQ_W'(rh));
    rad_nxt = sphere ? ((SQ_W'(rh) << 1) - SQ_W'(d)) : SQ_W'(d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1_r <= x[X_W-1];
      sy1_r <= y[X_W-1];
      ax1_r <= x[X_W-1] ? nx[MAG_W-1:0] : x[MAG_W-1:0];
      ay1_r <= y[X_W-1] ? ny[MAG_W-1:0] : y[MAG_W-1:0];
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      sqx_r <= ax1_r * ax1_r;
      sqy_r <= ay1_r * ay1_r;
      rad_r <= rad_nxt;
      tag_r <= '{sphere: sphere, sx: sx2_r, sy: sy2_r, ax: ax2_r, ay: ay2_r, d: d};
    end
  end

  assign v_out   = v3_r;
  assign rad_out = rad_r;
  assign tag_out = tag_r;

endmodule
`default_nettype wire
